// ===== hw/rtl/wsm_pkg.sv =====
// wsm_pkg: shared types and constants for the wildcard star matcher
// used by wsm_cell and wildcard_star_match_top; no dependencies
package wsm_pkg;

   // pattern store depth and width of lengths and cell indexes
   localparam int PATTERN_MAX = 32;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

   // the wildcard byte
   localparam logic [7:0] STAR_CHAR = 8'h2a;

   // beat commands
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_STRING = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic             fire;
      cmd_type          cmd;
      logic [7:0]       chr;
      logic             wr_en;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] len_next;
   } ctrl_type;

   // handed from each cell to its right neighbor
   typedef struct packed {
      logic match;
      logic raw;
      logic star_vld;
      logic first;
      logic star_vld_next;
   } link_type;

endpackage

// ===== hw/rtl/wsm_cell.sv =====
// wsm_cell: one pattern position, holding its byte and its live bit
// depends on wsm_pkg; instantiated as a row by wildcard_star_match_top
module wsm_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [wsm_pkg::LEN_W-1:0] index,
   input  wsm_pkg::ctrl_type         ctrl,
   input  wsm_pkg::link_type         left,
   output wsm_pkg::link_type         right,
   output logic                      end_hit
);
   import wsm_pkg::*;

   logic [7:0] char_ff, char_in;
   logic       live_ff, live_in;
   logic       valid, star_vld, first, wr;
   logic       valid_next, star_vld_next, match, raw, restart;

   // position status
   assign first    = (index == '0);
   assign valid    = (index < ctrl.len);
   assign star_vld = valid & (char_ff == STAR_CHAR);

   // pattern byte write at the current end of the pattern
   assign wr         = ctrl.wr_en & (index == ctrl.len);
   assign char_in    = wr ? ctrl.chr : char_ff;
   assign valid_next = (index < ctrl.len_next);
   assign star_vld_next = valid_next & (char_in == STAR_CHAR);

   // string byte step: literal match moves right, star holds
   assign match = live_ff & valid & (char_ff != STAR_CHAR) & (char_ff == ctrl.chr);
   assign raw   = (live_ff & star_vld) | left.match;

   // restart: position zero, plus its successor when it is a star
   assign restart = first | (left.first & left.star_vld_next);

   // next live bit
   always_comb begin
      live_in = live_ff;
      if (ctrl.fire) begin
         case (ctrl.cmd)
            CMD_STRING: live_in = raw | (left.raw & left.star_vld);
            default:    live_in = restart;
         endcase
      end
   end

   // live bit register
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= first;
      end else begin
         live_ff <= live_in;
      end
   end

   // pattern byte register
   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   // neighbor link and end-of-pattern tap
   assign right.match         = match;
   assign right.raw           = raw;
   assign right.star_vld      = star_vld;
   assign right.first         = first;
   assign right.star_vld_next = star_vld_next;
   assign end_hit             = live_ff & (index == ctrl.len);

endmodule

// ===== hw/rtl/wildcard_star_match_top.sv =====
// wildcard_star_match_top: glob matcher with '*' wildcard, row of wsm_cell
// depends on wsm_pkg and wsm_cell
//
// Usage: each req beat carries a command in req_tuser and a byte in
// req_tdata. Clear empties the pattern, append adds one pattern byte,
// string feeds one string byte, end closes the string and yields one rsp
// beat with matched and overflow. Only end beats produce rsp beats.
// Runs of stars are folded into one cell, since they match the same set.
// Every beat is handled in the cell row: one live bit per pattern
// position, each updated from its left neighbor, so a new beat is taken
// every cycle while req_tready is high. The rsp beat appears in the cycle after its end beat.
// The rsp side is a single output register: req_tready drops only while
// that register holds an untaken beat and rsp_tready is low.
// Reset empties the pattern, clears the overflow flag and the output;
// no clearing pass is needed.
// Appends past the store depth are dropped and flag overflow until clear.
module wildcard_star_match_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] character
   input  logic [1:0] req_tuser,   // [1:0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] overflow, [7:2] zero
);
   import wsm_pkg::*;

   logic [LEN_W-1:0]   len_ff, len_in, raw_len_ff, raw_len_in;
   logic               ovf_ff, ovf_in, last_star_ff, last_star_in;
   logic               rsp_valid_ff, rsp_valid_in, matched_ff, matched_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               fire, room, is_star, appending, hit, wr_en;
   cmd_type            cmd;
   ctrl_type           ctrl;
   link_type           links [0:PATTERN_MAX+1];
   logic [PATTERN_MAX:0] hits;

   // handshake
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign fire       = req_tvalid & req_tready;
   assign cmd        = cmd_type'(req_tuser);

   // pattern append control
   assign room      = (raw_len_ff < LEN_W'(PATTERN_MAX));
   assign is_star   = (req_tdata == STAR_CHAR);
   assign appending = fire & (cmd == CMD_APPEND);

   // pattern length, overflow and star folding state
   always_comb begin
      len_in       = len_ff;
      raw_len_in   = raw_len_ff;
      ovf_in       = ovf_ff;
      last_star_in = last_star_ff;
      wr_en        = 1'b0;
      if (fire && cmd == CMD_CLEAR) begin
         len_in       = '0;
         raw_len_in   = '0;
         ovf_in       = 1'b0;
         last_star_in = 1'b0;
      end else if (appending) begin
         if (room) begin
            raw_len_in = raw_len_ff + LEN_W'(1);
            if (!(is_star && last_star_ff)) begin
               wr_en        = 1'b1;
               len_in       = len_ff + LEN_W'(1);
               last_star_in = is_star;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // broadcast to the cells
   assign ctrl.fire     = fire;
   assign ctrl.cmd      = cmd;
   assign ctrl.chr      = req_tdata;
   assign ctrl.wr_en    = wr_en;
   assign ctrl.len      = len_ff;
   assign ctrl.len_next = len_in;

   // row of cells, one more than the store for the end position
   assign links[0] = '0;
   for (genvar g = 0; g <= PATTERN_MAX; g++) begin : g_cell
      wsm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .index   (LEN_W'(g)),
         .ctrl    (ctrl),
         .left    (links[g]),
         .right   (links[g+1]),
         .end_hit (hits[g])
      );
   end

   // live bit at the end of the pattern
   assign hit = |hits;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire && cmd == CMD_END) begin
         rsp_valid_in = 1'b1;
         matched_in   = hit & ~ovf_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         raw_len_ff   <= '0;
         ovf_ff       <= 1'b0;
         last_star_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         raw_len_ff   <= raw_len_in;
         ovf_ff       <= ovf_in;
         last_star_ff <= last_star_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, matched_ff};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for wildcard_star_match_top, glob match with '*'
// predicts matched/overflow for each end beat and checks the rsp stream in order
// depends on wsm_pkg and the matcher rtl
module tb_top;
   import wsm_pkg::*;

   localparam int TOTAL_BEATS = 950;
   localparam int QUIET_BEATS = 100;
   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic matched;
      logic overflow;
   } match_result_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] character
   logic [1:0] req_tuser;   // [1:0] command
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] matched, [1] overflow, [7:2] zero

   // predictor state: pattern bytes, length, live positions, overflow
   logic [7:0]           pat_mem [PATTERN_MAX];
   int unsigned          pat_len;
   logic [PATTERN_MAX:0] live;
   logic                 pat_ovf;

   match_result_type match_expect_q[$];
   match_result_type front_res;

   int  fail_count;
   int  beats_sent;
   int  stuck_cycles;
   int  rsp_hold_left;
   bit  req_idle_on;
   bit  rsp_idle_on;

   wildcard_star_match_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // a star position makes its successor live, scanned upward so runs close
   function void close_stars();
      for (int i = 0; i < pat_len; i++)
         if (live[i] && pat_mem[i] == STAR_CHAR) live[i + 1] = 1'b1;
   endfunction

   function void restart_live();
      live    = '0;
      live[0] = 1'b1;
      close_stars();
   endfunction

   // one string byte moves every live position
   function void advance_live(input logic [7:0] chr);
      logic [PATTERN_MAX:0] nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
         if (live[i]) begin
            if (pat_mem[i] == STAR_CHAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == chr) nxt[i + 1] = 1'b1;
         end
      end
      live = nxt;
      close_stars();
   endfunction

   // update the predicted matcher state for one accepted req beat
   function void predict_match_beat(input cmd_type cmd, input logic [7:0] chr);
      match_result_type res;
      case (cmd)
         CMD_CLEAR: begin
            pat_len = 0;
            pat_ovf = 1'b0;
            restart_live();
         end
         CMD_APPEND: begin
            if (pat_len < PATTERN_MAX) begin
               pat_mem[pat_len] = chr;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
            restart_live();
         end
         CMD_STRING: begin
            advance_live(chr);
         end
         default: begin
            res.matched  = live[pat_len] && !pat_ovf;
            res.overflow = pat_ovf;
            match_expect_q.push_back(res);
            restart_live();
         end
      endcase
   endfunction

   // biased byte choice so patterns and strings collide often
   function automatic logic [7:0] pick_glob_byte(input bit for_pattern);
      int unsigned r;
      r = $urandom_range(0, for_pattern ? 11 : 9);
      if (r < 4) return 8'h61;
      else if (r < 6) return 8'h62;
      else if (r == 6) return 8'h00;
      else if (r == 7) return 8'hff;
      else if (r == 8) return 8'($urandom_range(0, 255));
      else if (r == 9) return for_pattern ? STAR_CHAR : 8'h22;
      else return STAR_CHAR;
   endfunction

   // a string that fits the pattern, sometimes damaged by one edit
   function automatic byte_q_type make_subject(input byte_q_type pat);
      byte_q_type  subj;
      int unsigned idx;
      foreach (pat[i]) begin
         if (pat[i] == STAR_CHAR) begin
            repeat ($urandom_range(0, 3)) subj.push_back(pick_glob_byte(1'b0));
         end else begin
            subj.push_back(pat[i]);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         if (subj.size() == 0) begin
            subj.push_back(pick_glob_byte(1'b0));
         end else begin
            idx = $urandom_range(0, subj.size() - 1);
            case ($urandom_range(0, 2))
               0: subj[idx] = pick_glob_byte(1'b0);
               1: subj.delete(idx);
               default: subj.insert(idx, pick_glob_byte(1'b0));
            endcase
         end
      end
      return subj;
   endfunction

   // drive one req beat at the falling edge and wait for its handshake
   task automatic send_beat(input cmd_type cmd, input logic [7:0] chr);
      int gap;
      gap = 0;
      if (req_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= chr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_match_beat(cmd, chr);
      beats_sent++;
   endtask

   task automatic send_pattern(input byte_q_type pat);
      foreach (pat[i]) send_beat(CMD_APPEND, pat[i]);
   endtask

   task automatic send_subject(input byte_q_type subj);
      foreach (subj[i]) send_beat(CMD_STRING, subj[i]);
      send_beat(CMD_END, 8'($urandom_range(0, 255)));
   endtask

   // hold the sender idle until every predicted result has come back
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (match_expect_q.size() != 0) @(posedge clock);
   endtask

   // extremes, every command, star runs, byte zero, quotes, abandoned string
   task automatic test_directed();
      send_beat(CMD_END, 8'h00);           // empty pattern, empty string
      send_beat(CMD_STRING, 8'h00);
      send_beat(CMD_END, 8'hff);           // empty pattern, non-empty string
      send_beat(CMD_APPEND, STAR_CHAR);
      send_beat(CMD_END, 8'h00);           // lone star on empty string
      send_beat(CMD_STRING, 8'hff);
      send_beat(CMD_STRING, STAR_CHAR);
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_CLEAR, 8'hff);
      send_beat(CMD_APPEND, 8'h61);
      send_beat(CMD_APPEND, 8'h00);
      send_beat(CMD_APPEND, STAR_CHAR);
      send_beat(CMD_APPEND, STAR_CHAR);
      send_beat(CMD_APPEND, 8'hff);
      send_beat(CMD_STRING, 8'h61);
      send_beat(CMD_STRING, 8'h00);
      send_beat(CMD_STRING, 8'h27);
      send_beat(CMD_STRING, 8'hff);
      send_beat(CMD_END, 8'h00);
      // append in the middle of a string throws the string away
      send_beat(CMD_STRING, 8'h61);
      send_beat(CMD_APPEND, 8'h22);
      send_beat(CMD_STRING, 8'h61);
      send_beat(CMD_STRING, 8'h00);
      send_beat(CMD_STRING, 8'hff);
      send_beat(CMD_STRING, 8'h22);
      send_beat(CMD_END, 8'h00);
   endtask

   // full store, then one append too many, then clear
   task automatic test_pattern_overflow();
      byte_q_type pat;
      send_beat(CMD_CLEAR, 8'h00);
      repeat (PATTERN_MAX - 1) pat.push_back(pick_glob_byte(1'b1));
      pat.push_back(STAR_CHAR);
      send_pattern(pat);
      send_subject(make_subject(pat));
      send_beat(CMD_APPEND, 8'h61);
      send_beat(CMD_END, 8'h00);
      send_subject(make_subject(pat));
      send_beat(CMD_CLEAR, 8'h00);
      send_beat(CMD_END, 8'h00);
   endtask

   // rsp side held off long enough that the output register fills
   task automatic test_output_stall();
      byte_q_type pat;
      pat = '{8'h61, STAR_CHAR};
      send_beat(CMD_CLEAR, 8'h00);
      send_pattern(pat);
      rsp_hold_left = HOLD_CYCLES;
      repeat (10) send_subject(make_subject(pat));
      wait_results_drained();
      repeat (8) send_subject(make_subject(pat));
   endtask

   // mostly well-formed pattern/string sequences, some raw noise
   task automatic test_random();
      byte_q_type pat;
      int         plen;
      while (beats_sent < TOTAL_BEATS) begin
         if (beats_sent >= TOTAL_BEATS - QUIET_BEATS) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end else begin
            req_idle_on = ($urandom_range(0, 2) != 0);
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 3) != 0) send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(PATTERN_MAX - 2, PATTERN_MAX + 3)
                                                : $urandom_range(0, 8);
            pat.delete();
            repeat (plen) pat.push_back(pick_glob_byte(1'b1));
            send_pattern(pat);
            repeat ($urandom_range(1, 4)) send_subject(make_subject(pat));
         end else begin
            repeat ($urandom_range(1, 6))
               send_beat(cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // rsp_tready: long hold when asked, else random stall bursts
   initial begin : rsp_ready_gen
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each rsp beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (match_expect_q.size() == 0) begin
            $display("%0t: rsp beat with nothing expected, actual tdata %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            front_res = match_expect_q.pop_front();
            if (rsp_tdata[0] !== front_res.matched) begin
               $display("%0t: matched expected %0b actual %0b",
                        $time, front_res.matched, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[1] !== front_res.overflow) begin
               $display("%0t: overflow expected %0b actual %0b",
                        $time, front_res.overflow, rsp_tdata[1]);
               fail_count++;
            end
            if (rsp_tdata[7:2] !== 6'd0) begin
               $display("%0t: pad bits expected 0 actual %b", $time, rsp_tdata[7:2]);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tuser     = CMD_CLEAR;
      fail_count    = 0;
      beats_sent    = 0;
      stuck_cycles  = 0;
      rsp_hold_left = 0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      pat_len       = 0;
      pat_ovf       = 1'b0;
      restart_live();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_pattern_overflow();
      test_output_stall();
      test_random();

      wait_results_drained();
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== wildcard_star_match_top.f =====
hw/rtl/wsm_pkg.sv
hw/rtl/wsm_cell.sv
hw/rtl/wildcard_star_match_top.sv
bench/tb_top.sv
